// ===== rtl/vlps_pkg.sv =====
// ----------------------------------------------------------------------------
// vlps_pkg: shared types and constants for the varint length-prefixed serializer
// Transaction payload structs, action codes and length counter width.
// ----------------------------------------------------------------------------
package vlps_pkg;

  localparam int unsigned LENGTH_BITS = 32;

  localparam logic [3:0] ACT_BYTE     = 4'd0;
  localparam logic [3:0] ACT_SHORT_BE = 4'd1;
  localparam logic [3:0] ACT_SHORT_LE = 4'd2;
  localparam logic [3:0] ACT_INT_BE   = 4'd3;
  localparam logic [3:0] ACT_INT_LE   = 4'd4;
  localparam logic [3:0] ACT_LONG_BE  = 4'd5;
  localparam logic [3:0] ACT_LONG_LE  = 4'd6;
  localparam logic [3:0] ACT_VARINT32 = 4'd7;
  localparam logic [3:0] ACT_VARINT64 = 4'd8;
  localparam logic [3:0] ACT_FINALIZE = 4'd9;
  localparam logic [3:0] ACT_CLEAR    = 4'd10;

  localparam logic [6:0] GROUP_MASK = 7'h7f;

  typedef struct packed {
    logic [3:0]  action;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_prefix;
    logic       last;
  } out_item_t;

endpackage

// ===== rtl/varint_length_prefixed_serializer.sv =====
// Sequencing: an item's bytes pass one by one into the output register, and
// the next item is taken only after the last of them is there (clear, finalize
// of an empty packet and unused codes emit no bytes and leave the block ready).
// One byte is produced per cycle while the output is not stalled, by a shared
// 64-bit shifter under a two-state sequencer. Reset is asynchronous, active
// low, and zeroes the length.
// ----------------------------------------------------------------------------
// varint_length_prefixed_serializer: typed field to byte stream serializer
// Emits fixed-width fields in either byte order or as 7-bit-group varints,
// counts field bytes (saturating) and emits the count as a varint prefix.
// ----------------------------------------------------------------------------
module varint_length_prefixed_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vlps_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vlps_pkg::out_item_t out_item_o
);
  import vlps_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                   state_q, state_d;
  logic [63:0]            sr_q, sr_d;
  logic [3:0]             cnt_q, cnt_d;
  logic                   varint_q, varint_d;
  logic                   prefix_q, prefix_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic        in_fire;
  logic        out_free;
  logic        more;
  logic [63:0] v;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign more        = |sr_q[63:7];
  assign v           = in_item_i.value;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    sr_d        = sr_q;
    cnt_d       = cnt_q;
    varint_d    = varint_q;
    prefix_d    = prefix_q;
    len_d       = len_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_fire) begin
      varint_d = 1'b0;
      prefix_d = 1'b0;
      case (in_item_i.action)
        ACT_BYTE: begin
          sr_d = {56'd0, v[7:0]};
          cnt_d = 4'd1;
          state_d = ST_EMIT;
        end
        ACT_SHORT_BE: begin
          sr_d = {48'd0, v[7:0], v[15:8]};
          cnt_d = 4'd2;
          state_d = ST_EMIT;
        end
        ACT_SHORT_LE: begin
          sr_d = {48'd0, v[15:0]};
          cnt_d = 4'd2;
          state_d = ST_EMIT;
        end
        ACT_INT_BE: begin
          sr_d = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
          cnt_d = 4'd4;
          state_d = ST_EMIT;
        end
        ACT_INT_LE: begin
          sr_d = {32'd0, v[31:0]};
          cnt_d = 4'd4;
          state_d = ST_EMIT;
        end
        ACT_LONG_BE: begin
          sr_d = {v[7:0], v[15:8], v[23:16], v[31:24],
                  v[39:32], v[47:40], v[55:48], v[63:56]};
          cnt_d = 4'd8;
          state_d = ST_EMIT;
        end
        ACT_LONG_LE: begin
          sr_d = v;
          cnt_d = 4'd8;
          state_d = ST_EMIT;
        end
        ACT_VARINT32: begin
          sr_d = {32'd0, v[31:0]};
          varint_d = 1'b1;
          state_d = ST_EMIT;
        end
        ACT_VARINT64: begin
          sr_d = v;
          varint_d = 1'b1;
          state_d = ST_EMIT;
        end
        ACT_FINALIZE: begin
          // empty packet: no prefix at all
          if (len_q != '0) begin
            sr_d = 64'(len_q);
            varint_d = 1'b1;
            prefix_d = 1'b1;
            state_d = ST_EMIT;
          end
        end
        ACT_CLEAR: begin
          len_d = '0;
        end
        default: begin
        end
      endcase
    end else if (state_q == ST_EMIT && out_free) begin
      out_valid_d     = 1'b1;
      out_d.is_prefix = prefix_q;
      if (varint_q) begin
        out_d.out_byte = {more, sr_q[6:0] & GROUP_MASK};
        out_d.last     = !more;
        sr_d           = {7'd0, sr_q[63:7]};
      end else begin
        out_d.out_byte = sr_q[7:0];
        out_d.last     = (cnt_q == 4'd1);
        sr_d           = {8'd0, sr_q[63:8]};
        cnt_d          = cnt_q - 4'd1;
      end
      if (out_d.last) begin
        state_d = ST_IDLE;
      end
      // field bytes count toward the payload length, saturating
      if (!prefix_q && len_q != '1) begin
        len_d = len_q + LENGTH_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      varint_q    <= 1'b0;
      prefix_q    <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      varint_q    <= varint_d;
      prefix_q    <= prefix_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q  <= sr_d;
    out_q <= out_d;
  end

endmodule

// ===== rtl/vlps_checker.sv =====
// ----------------------------------------------------------------------------
// vlps_sva: port-level checks for the varint length-prefixed serializer
// Watches the handshakes and byte stream of the top level; bound below.
// ----------------------------------------------------------------------------
module vlps_sva (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input vlps_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vlps_pkg::out_item_t out_item_o
);
  import vlps_pkg::*;

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output transaction changed while stalled");

  // a field item always produces bytes, so the block is busy next cycle
  a_field_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (in_item_i.action == ACT_BYTE || in_item_i.action == ACT_SHORT_BE ||
     in_item_i.action == ACT_SHORT_LE || in_item_i.action == ACT_INT_BE ||
     in_item_i.action == ACT_INT_LE || in_item_i.action == ACT_LONG_BE ||
     in_item_i.action == ACT_LONG_LE || in_item_i.action == ACT_VARINT32 ||
     in_item_i.action == ACT_VARINT64) |=> !in_ready_o)
    else $error("field item did not occupy the block");

  // while a non-final byte is shown, more bytes are pending
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> !in_ready_o)
    else $error("new input taken mid-field");

  // prefix varint: continuation bit set on every byte but the last
  a_prefix_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_prefix |->
      out_item_o.out_byte[7] == !out_item_o.last)
    else $error("bad continuation bit in length prefix");

endmodule

bind varint_length_prefixed_serializer vlps_sva u_vlps_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
